[hw/rtl/temperature_to_servo_pwm_unit_macros.svh]
// Assertion macros shared by the temperature-to-servo PWM RTL.
`ifndef TEMPERATURE_TO_SERVO_PWM_UNIT_MACROS_SVH
`define TEMPERATURE_TO_SERVO_PWM_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tsp_pkg.sv]
// Package with constants, types and helpers of the temperature-to-servo PWM unit.
`timescale 1ns / 1ps

package tsp_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int PERIOD_TICKS = 20000;
    // 80 * sample magnitude needs 7 extra bits
    localparam int NUM_BITS     = SAMPLE_BITS + 7;
    localparam int POS_BITS     = $clog2(PERIOD_TICKS);
    localparam int CNT_BITS     = $clog2(NUM_BITS + 1);
    localparam int ADDR_BITS    = 3;

    localparam logic [11:0] WIDTH_MIN  = 12'd600;
    localparam logic [11:0] WIDTH_MAX  = 12'd2400;
    localparam logic [7:0]  TEMP_BASE  = 8'd30;
    localparam logic [7:0]  TEMP_LOW   = 8'd35;
    localparam logic [7:0]  TEMP_HIGH  = 8'd60;
    localparam logic [12:0] WIDTH_GAIN = 13'd72;
    localparam logic [12:0] WIDTH_OFFS = 13'd1920;

    localparam logic [SAMPLE_BITS-1:0] CAL_HIGH_RST = SAMPLE_BITS'(4095);

    // register index decoded from paddr[2]
    localparam logic REG_CAL_LOW  = 1'b0;
    localparam logic REG_CAL_HIGH = 1'b1;

    // tuser codes on the input stream
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_WB
    } t_state;

    // servo pulse width in ticks for a temperature
    function automatic logic [11:0] width_for(logic [7:0] t);
        logic [12:0] prod;
        prod = 13'(t) * WIDTH_GAIN - WIDTH_OFFS;
        if (t <= TEMP_LOW) begin
            return WIDTH_MIN;
        end else if (t < TEMP_HIGH) begin
            return prod[11:0];
        end else begin
            return WIDTH_MAX;
        end
    endfunction

endpackage

[hw/rtl/temperature_to_servo_pwm_unit.sv]
// Top level of the temperature-to-servo PWM unit: divider sequencer, PWM counter, APB registers.
`timescale 1ns / 1ps

// Every request on the input stream gives exactly one result request. tuser selects the kind:
// a tick request (tuser = 1) steps the PWM period counter without leaving the idle state, so ticks
// can follow back to back while the output slot drains. A sample request (tuser = 0) is turned
// into a temperature with the two calibration points, 80*(sample-cal_low)/(cal_high-cal_low)+30
// truncated toward zero and wrapped to 8 bits, then mapped to a servo width that loads at the
// next period start. A sample goes through accept, forming of operand magnitudes, one quotient
// bit per cycle in the restoring subtract/compare unit, and write back, which waits for a free
// output slot; s_tready stays low throughout. Equal calibration points end the division after
// its first step and flag cal_error, keeping the old temperature and width. The output
// request sits in a register; a new request is taken only while that register is empty or
// drains in the same cycle. Calibration is written over APB at 0x0 (cal_low) and 0x4
// (cal_high) and should only be changed while the unit is idle.
module temperature_to_servo_pwm_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  logic        s_tuser,   // [0] command: 0 sample, 1 tick
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] temperature, [19:8] pulse_width, [20] pin_level,
                                   // [21] period_start, [22] cal_error, [23] zero
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsp_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SB = tsp_pkg::SAMPLE_BITS;
    localparam int NB = tsp_pkg::NUM_BITS;
    localparam int PB = tsp_pkg::POS_BITS;
    localparam int CB = tsp_pkg::CNT_BITS;

    // ---------------- configuration ----------------
    logic [SB-1:0] r_cal_low;
    logic [SB-1:0] r_cal_high;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_low  <= '0;
            r_cal_high <= tsp_pkg::CAL_HIGH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                tsp_pkg::REG_CAL_LOW:  r_cal_low  <= pwdata[SB-1:0];
                tsp_pkg::REG_CAL_HIGH: r_cal_high <= pwdata[SB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tsp_pkg::REG_CAL_LOW:  prdata = 32'(r_cal_low);
            tsp_pkg::REG_CAL_HIGH: prdata = 32'(r_cal_high);
            default:               prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    tsp_pkg::t_state r_state, n_state;

    logic          out_free;      // output slot empty or being drained
    logic          s_acc;
    logic          acc_tick;
    logic          acc_sample;
    logic          ld_sample;     // write back a finished sample

    logic [CB-1:0] r_cnt;
    logic          div_last;

    assign out_free   = !m_tvalid || m_tready;
    assign s_acc      = s_tvalid && s_tready;
    assign acc_tick   = s_acc && (s_tuser == tsp_pkg::CMD_TICK);
    assign acc_sample = s_acc && (s_tuser == tsp_pkg::CMD_SAMPLE);
    assign div_last   = (r_cnt == CB'(NB - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // r_err set in PREP means a zero divisor: go to write back after the first division step
    logic r_err;

    always_comb begin
        n_state   = r_state;
        s_tready  = 1'b0;
        ld_sample = 1'b0;
        unique case (r_state)
            tsp_pkg::S_IDLE: begin
                s_tready = out_free;
                if (acc_sample) begin
                    n_state = tsp_pkg::S_PREP;
                end
            end
            tsp_pkg::S_PREP: begin
                n_state = tsp_pkg::S_DIV;
            end
            tsp_pkg::S_DIV: begin
                if (r_err || div_last) begin
                    n_state = tsp_pkg::S_WB;
                end
            end
            tsp_pkg::S_WB: begin
                if (out_free) begin
                    ld_sample = 1'b1;
                    n_state   = tsp_pkg::S_IDLE;
                end
            end
            default: n_state = tsp_pkg::S_IDLE;
        endcase
    end

    // ---------------- divider datapath ----------------
    // Operands are split into sign and magnitude; the magnitude quotient is shifted
    // into r_quo one bit a cycle and the sign applied at write back.
    logic signed [SB:0] r_diff;
    logic [NB-1:0]      r_quo;
    logic [SB-1:0]      r_rem;
    logic [SB-1:0]      r_den;
    logic               r_neg;

    logic signed [SB:0] den_s;
    logic [SB-1:0]      diff_mag;
    logic [SB-1:0]      den_mag;
    logic [NB-1:0]      num_mag;
    logic [SB:0]        rem_sh;
    logic [SB:0]        rem_sub;
    logic               rem_ge;

    assign den_s    = $signed({1'b0, r_cal_high}) - $signed({1'b0, r_cal_low});
    assign diff_mag = r_diff[SB] ? SB'(-r_diff) : r_diff[SB-1:0];
    assign den_mag  = den_s[SB] ? SB'(-den_s) : den_s[SB-1:0];
    // times 80 as 64 + 16
    assign num_mag  = (NB'(diff_mag) << 6) + (NB'(diff_mag) << 4);

    assign rem_sh   = {r_rem, r_quo[NB-1]};
    assign rem_sub  = rem_sh - {1'b0, r_den};
    assign rem_ge   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (acc_sample) begin
            r_diff <= $signed({1'b0, s_tdata[SB-1:0]}) - $signed({1'b0, r_cal_low});
        end
        unique case (r_state)
            tsp_pkg::S_PREP: begin
                r_quo <= num_mag;
                r_rem <= '0;
                r_den <= den_mag;
                r_neg <= r_diff[SB] ^ den_s[SB];
                r_err <= (den_s == '0);
                r_cnt <= '0;
            end
            tsp_pkg::S_DIV: begin
                r_rem <= rem_ge ? rem_sub[SB-1:0] : rem_sh[SB-1:0];
                r_quo <= {r_quo[NB-2:0], rem_ge};
                r_cnt <= r_cnt + CB'(1);
            end
            default: ;
        endcase
    end

    // quotient low byte with sign, then temperature and width
    logic [7:0]  quo8;
    logic [7:0]  temp_new;
    logic [11:0] width_new;

    assign quo8      = r_neg ? 8'(-r_quo[7:0]) : r_quo[7:0];
    assign temp_new  = quo8 + tsp_pkg::TEMP_BASE;
    assign width_new = tsp_pkg::width_for(temp_new);

    // ---------------- PWM state ----------------
    logic [PB-1:0] r_pos;
    logic [11:0]   r_active;
    logic [11:0]   r_pending;
    logic [7:0]    r_last_temp;
    logic          r_pin;

    logic          tick_start;
    logic [11:0]   tick_active;
    logic          tick_pin;
    logic [PB-1:0] tick_pos_nx;

    assign tick_start  = (r_pos == '0);
    assign tick_active = tick_start ? r_pending : r_active;
    assign tick_pin    = 32'(r_pos) < 32'(tick_active);
    assign tick_pos_nx = (r_pos == PB'(tsp_pkg::PERIOD_TICKS - 1)) ? '0 : r_pos + PB'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_active    <= '0;
            r_pending   <= '0;
            r_last_temp <= '0;
            r_pin       <= 1'b0;
        end else begin
            if (acc_tick) begin
                r_pos    <= tick_pos_nx;
                r_active <= tick_active;
                r_pin    <= tick_pin;
            end
            if (ld_sample && !r_err) begin
                r_last_temp <= temp_new;
                r_pending   <= width_new;
            end
        end
    end

    // ---------------- output register ----------------
    logic        r_m_valid;
    logic [7:0]  r_o_temp;
    logic [11:0] r_o_width;
    logic        r_o_pin;
    logic        r_o_start;
    logic        r_o_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (acc_tick || ld_sample) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_tick) begin
            r_o_temp  <= r_last_temp;
            r_o_width <= r_pending;
            r_o_pin   <= tick_pin;
            r_o_start <= tick_start;
            r_o_err   <= 1'b0;
        end else if (ld_sample) begin
            r_o_temp  <= r_err ? r_last_temp : temp_new;
            r_o_width <= r_err ? r_pending : width_new;
            r_o_pin   <= r_pin;
            r_o_start <= 1'b0;
            r_o_err   <= r_err;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {1'b0, r_o_err, r_o_start, r_o_pin, r_o_width, r_o_temp};

    // ---------------- checks ----------------
`include "temperature_to_servo_pwm_unit_macros.svh"

    `TSP_ASSERT_NEXT(a_busy_after_sample, acc_sample, !s_tready, "ready after sample accept")
    `TSP_ASSERT_NOW(a_pos_range, 1'b1, 32'(r_pos) < tsp_pkg::PERIOD_TICKS, "period position out of range")
    `TSP_ASSERT_NOW(a_err_no_start, m_tvalid, !(r_o_err && r_o_start), "error result marks period start")
    `TSP_ASSERT_NOW(a_width_range, 1'b1, (r_pending == '0) || ((r_pending >= tsp_pkg::WIDTH_MIN) && (r_pending <= tsp_pkg::WIDTH_MAX)), "pending width out of range")

endmodule
